/* hdl/tcsd_pkg.sv */
// ----------------------------------------------------------------------------
// tcsd_pkg: shared types and constants for the tile cell to sprite unit
// Word layout of the divider chain, configuration bundle and register codes.
// ----------------------------------------------------------------------------
package tcsd_pkg;

	localparam int IDX_W    = 16;  // tile index bits below the sign bit
	localparam int COLS_W   = 13;  // atlas column count width
	localparam int COORD_W  = 12;  // map column and row width
	localparam int FLAG_W   = 3;
	localparam int TSIZE_W  = 9;
	localparam int GAP_W    = 8;
	localparam int OFF_W    = 22;
	localparam int SRC_W    = 22;
	localparam int DEST_W   = 24;
	localparam int CFG_W    = 22;
	localparam int CFG_IDX_W = 3;

	// flag bit positions
	localparam int FLAG_H = 2;
	localparam int FLAG_V = 1;
	localparam int FLAG_D = 0;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_TILE_WIDTH    = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_TILE_HEIGHT   = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_ATLAS_MARGIN  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_ATLAS_SPACING = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_ATLAS_COLUMNS = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_MAP_WIDTH     = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_OFFSET_X      = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_OFFSET_Y      = 3'd7;

	// one word traveling down the divider chain
	typedef struct packed {
		logic [IDX_W-1:0]   num;   // dividend bits shift out, quotient bits shift in
		logic [COLS_W-1:0]  rem;
		logic [FLAG_W-1:0]  flags;
		logic [COORD_W-1:0] col;
		logic [COORD_W-1:0] row;
	} tcsd_word_t;

	typedef struct packed {
		logic [TSIZE_W-1:0] tile_width;
		logic [TSIZE_W-1:0] tile_height;
		logic [GAP_W-1:0]   margin;
		logic [GAP_W-1:0]   spacing;
		logic [OFF_W-1:0]   offset_x;
		logic [OFF_W-1:0]   offset_y;
	} tcsd_cfg_t;

endpackage

/* hdl/tcsd_div_cell.sv */
// ----------------------------------------------------------------------------
// tcsd_div_cell: one restoring division step
// Takes one dividend bit into the remainder, subtracts the column count when
// it fits and shifts the quotient bit in. Registered, with its own handshake.
// ----------------------------------------------------------------------------
module tcsd_div_cell import tcsd_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic [COLS_W-1:0] cols,
	input  logic              up_valid,
	output logic              up_ready,
	input  tcsd_word_t        up_word,
	output logic              down_valid,
	input  logic              down_ready,
	output tcsd_word_t        down_word
);

	logic [COLS_W:0] trial;
	logic [COLS_W:0] diff;
	logic            take;
	tcsd_word_t      next_word;
	logic            valid_q;
	tcsd_word_t      word_q;

	always_comb begin
		trial = {up_word.rem, up_word.num[IDX_W-1]};
		diff  = trial - {1'b0, cols};
		take  = trial >= {1'b0, cols};
		next_word      = up_word;
		next_word.rem  = take ? diff[COLS_W-1:0] : trial[COLS_W-1:0];
		next_word.num  = {up_word.num[IDX_W-2:0], take};
	end

	// advance when empty or when the neighbor takes our word
	assign up_ready = !valid_q || down_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (up_ready) begin
			valid_q <= up_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (up_ready && up_valid) begin
			word_q <= next_word;
		end
	end

	assign down_valid = valid_q;
	assign down_word  = word_q;

endmodule

/* hdl/tcsd_finish.sv */
// ----------------------------------------------------------------------------
// tcsd_finish: source and destination corners from the divided index
// Stage one forms the products, the output register adds offsets,
// saturates the source corner and resolves the flip flags.
// ----------------------------------------------------------------------------
module tcsd_finish import tcsd_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  tcsd_cfg_t                cfg,
	input  logic                     up_valid,
	output logic                     up_ready,
	input  tcsd_word_t               up_word,
	output logic                     out_valid,
	input  logic                     out_ready,
	output logic [SRC_W-1:0]         src_x,
	output logic [SRC_W-1:0]         src_y,
	output logic signed [DEST_W-1:0] dest_x_half,
	output logic signed [DEST_W-1:0] dest_y_half,
	output logic                     mirror_x,
	output logic                     mirror_y,
	output logic                     rotate_90
);

	localparam int PX_W = COLS_W + TSIZE_W + 1;
	localparam int PY_W = IDX_W + TSIZE_W + 1;
	localparam int POS_W = COORD_W + TSIZE_W;

	logic [TSIZE_W:0]        pitch_x;
	logic [TSIZE_W:0]        pitch_y;
	logic                    valid_s1;
	logic                    ready_s1;
	logic [PX_W-1:0]         prod_x_s1;
	logic [PY_W-1:0]         prod_y_s1;
	logic [POS_W-1:0]        pos_x_s1;
	logic [POS_W-1:0]        pos_y_s1;
	logic [FLAG_W-1:0]       flags_s1;
	logic [PX_W:0]           sum_x;
	logic [PY_W:0]           sum_y;
	logic [TSIZE_W-1:0]      anchor_x;
	logic [DEST_W-1:0]       dx;
	logic [DEST_W-1:0]       dy;
	logic                    fh, fv, fd;
	logic                    out_valid_q;
	logic [SRC_W-1:0]        src_x_q, src_y_q;
	logic [DEST_W-1:0]       dest_x_q, dest_y_q;
	logic                    mirror_x_q, mirror_y_q, rotate_q;

	assign pitch_x = {1'b0, cfg.tile_width}  + {2'b0, cfg.spacing};
	assign pitch_y = {1'b0, cfg.tile_height} + {2'b0, cfg.spacing};

	assign ready_s1 = !out_valid_q || out_ready;
	assign up_ready = !valid_s1 || ready_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (up_ready) begin
			valid_s1 <= up_valid;
		end
	end

	// remainder is the atlas column, quotient the atlas row
	always_ff @(posedge clk) begin
		if (up_ready && up_valid) begin
			prod_x_s1 <= PX_W'(up_word.rem) * PX_W'(pitch_x);
			prod_y_s1 <= PY_W'(up_word.num) * PY_W'(pitch_y);
			pos_x_s1  <= POS_W'(up_word.col) * POS_W'(cfg.tile_width);
			pos_y_s1  <= POS_W'(up_word.row) * POS_W'(cfg.tile_height);
			flags_s1  <= up_word.flags;
		end
	end

	always_comb begin
		fh = flags_s1[FLAG_H];
		fv = flags_s1[FLAG_V];
		fd = flags_s1[FLAG_D];
		sum_x = {{(PX_W + 1 - GAP_W){1'b0}}, cfg.margin} + {1'b0, prod_x_s1};
		sum_y = {{(PY_W + 1 - GAP_W){1'b0}}, cfg.margin} + {1'b0, prod_y_s1};
		// diagonal flip moves the centre offset to the other tile side
		anchor_x = fd ? cfg.tile_height : cfg.tile_width;
		dx = {{(DEST_W - OFF_W){cfg.offset_x[OFF_W-1]}}, cfg.offset_x}
			+ {{(DEST_W - POS_W - 1){1'b0}}, pos_x_s1, 1'b0}
			+ {{(DEST_W - TSIZE_W){1'b0}}, anchor_x};
		dy = {{(DEST_W - OFF_W){cfg.offset_y[OFF_W-1]}}, cfg.offset_y}
			+ {{(DEST_W - POS_W - 1){1'b0}}, pos_y_s1, 1'b0}
			+ {{(DEST_W - TSIZE_W){1'b0}}, cfg.tile_height}
			+ (fd ? ({{(DEST_W - TSIZE_W){1'b0}}, cfg.tile_height}
				- {{(DEST_W - TSIZE_W){1'b0}}, cfg.tile_width}) : '0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ready_s1) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (ready_s1 && valid_s1) begin
			src_x_q    <= (|sum_x[PX_W:SRC_W]) ? {SRC_W{1'b1}} : sum_x[SRC_W-1:0];
			src_y_q    <= (|sum_y[PY_W:SRC_W]) ? {SRC_W{1'b1}} : sum_y[SRC_W-1:0];
			dest_x_q   <= dx;
			dest_y_q   <= dy;
			mirror_x_q <= fd ? fv : fh;
			mirror_y_q <= fd ? !fh : fv;
			rotate_q   <= fd;
		end
	end

	assign out_valid   = out_valid_q;
	assign src_x       = src_x_q;
	assign src_y       = src_y_q;
	assign dest_x_half = dest_x_q;
	assign dest_y_half = dest_y_q;
	assign mirror_x    = mirror_x_q;
	assign mirror_y    = mirror_y_q;
	assign rotate_90   = rotate_q;

endmodule

/* hdl/tile_cell_to_sprite_descriptor_unit.sv */
// ----------------------------------------------------------------------------
// tile_cell_to_sprite_descriptor_unit: map cell to atlas sprite descriptor
// Divides the tile index by the atlas column count in a chain of one-bit
// division cells, then forms the source and destination corners.
// ----------------------------------------------------------------------------
// Pipeline: 16 division cells, a product stage and the output register lie
// between input accept and out_valid.
// Throughput: one cell word per cycle while out_ready holds; each division cell and stage holds
// one word and advances whenever the next one is free or drains.
// Empty cells (negative tile index) are accepted and dropped at the input.
// Reset clears all stage valid bits and loads the register defaults.
module tile_cell_to_sprite_descriptor_unit import tcsd_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     cfg_we,
	input  logic [CFG_IDX_W-1:0]     cfg_index,
	input  logic [CFG_W-1:0]         cfg_data,
	input  logic                     in_valid,
	output logic                     in_ready,
	input  logic signed [IDX_W:0]    tile_index,
	input  logic [FLAG_W-1:0]        flip_flags,
	input  logic [COORD_W-1:0]       cell_col,
	input  logic [COORD_W-1:0]       cell_row,
	output logic                     out_valid,
	input  logic                     out_ready,
	output logic [SRC_W-1:0]         src_x,
	output logic [SRC_W-1:0]         src_y,
	output logic signed [DEST_W-1:0] dest_x_half,
	output logic signed [DEST_W-1:0] dest_y_half,
	output logic                     mirror_x,
	output logic                     mirror_y,
	output logic                     rotate_90
);

	logic [TSIZE_W-1:0]  tile_width_q;
	logic [TSIZE_W-1:0]  tile_height_q;
	logic [GAP_W-1:0]    margin_q;
	logic [GAP_W-1:0]    spacing_q;
	logic [COLS_W-2:0]   atlas_cols_q;
	logic [COLS_W-1:0]   map_width_q;
	logic [OFF_W-1:0]    offset_x_q;
	logic [OFF_W-1:0]    offset_y_q;

	logic [COLS_W-1:0]   cols_raw;
	logic [COLS_W-1:0]   cols;
	tcsd_cfg_t           cfg;

	logic                chain_valid [0:IDX_W];
	logic                chain_ready [0:IDX_W];
	tcsd_word_t          chain_word  [0:IDX_W];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tile_width_q  <= TSIZE_W'(16);
			tile_height_q <= TSIZE_W'(16);
			margin_q      <= '0;
			spacing_q     <= '0;
			atlas_cols_q  <= '0;
			map_width_q   <= COLS_W'(64);
			offset_x_q    <= '0;
			offset_y_q    <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_TILE_WIDTH:    tile_width_q  <= cfg_data[TSIZE_W-1:0];
				REG_TILE_HEIGHT:   tile_height_q <= cfg_data[TSIZE_W-1:0];
				REG_ATLAS_MARGIN:  margin_q      <= cfg_data[GAP_W-1:0];
				REG_ATLAS_SPACING: spacing_q     <= cfg_data[GAP_W-1:0];
				REG_ATLAS_COLUMNS: atlas_cols_q  <= cfg_data[COLS_W-2:0];
				REG_MAP_WIDTH:     map_width_q   <= cfg_data[COLS_W-1:0];
				REG_OFFSET_X:      offset_x_q    <= cfg_data[OFF_W-1:0];
				REG_OFFSET_Y:      offset_y_q    <= cfg_data[OFF_W-1:0];
				default: ;
			endcase
		end
	end

	// zero atlas columns falls back to map width; zero both divides by one
	assign cols_raw = (atlas_cols_q != '0) ? {1'b0, atlas_cols_q} : map_width_q;
	assign cols     = (cols_raw == '0) ? COLS_W'(1) : cols_raw;

	always_comb begin
		cfg.tile_width  = tile_width_q;
		cfg.tile_height = tile_height_q;
		cfg.margin      = margin_q;
		cfg.spacing     = spacing_q;
		cfg.offset_x    = offset_x_q;
		cfg.offset_y    = offset_y_q;
	end

	// drop empty cells at the door
	always_comb begin
		chain_valid[0]      = in_valid && !tile_index[IDX_W];
		chain_word[0].num   = tile_index[IDX_W-1:0];
		chain_word[0].rem   = '0;
		chain_word[0].flags = flip_flags;
		chain_word[0].col   = cell_col;
		chain_word[0].row   = cell_row;
	end
	assign in_ready = chain_ready[0];

	for (genvar k = 0; k < IDX_W; k++) begin : g_div
		tcsd_div_cell u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.cols       (cols),
			.up_valid   (chain_valid[k]),
			.up_ready   (chain_ready[k]),
			.up_word    (chain_word[k]),
			.down_valid (chain_valid[k+1]),
			.down_ready (chain_ready[k+1]),
			.down_word  (chain_word[k+1])
		);
	end

	tcsd_finish u_finish (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg),
		.up_valid    (chain_valid[IDX_W]),
		.up_ready    (chain_ready[IDX_W]),
		.up_word     (chain_word[IDX_W]),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.src_x       (src_x),
		.src_y       (src_y),
		.dest_x_half (dest_x_half),
		.dest_y_half (dest_y_half),
		.mirror_x    (mirror_x),
		.mirror_y    (mirror_y),
		.rotate_90   (rotate_90)
	);

`ifndef SYNTHESIS
	a_rem_below_cols: assert property (@(posedge clk) disable iff (!arst_n)
		chain_valid[IDX_W] |-> chain_word[IDX_W].rem < cols)
		else $error("division remainder not below column count");

	a_empty_dropped: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready && tile_index[IDX_W] && !chain_valid[1])
		|=> !chain_valid[1])
		else $error("empty cell entered the divider chain");

	a_stall_only_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> (chain_valid[1] && !chain_ready[1]))
		else $error("input stalled with a free first cell");
`endif

endmodule

/* tb/tb_tile_cell_to_sprite_descriptor_unit.sv */
// ----------------------------------------------------------------------------
// tb_tile_cell_to_sprite_descriptor_unit: self-checking bench for the sprite unit
// Feeds map cells through the valid/ready input under several register
// settings and idling mixes. Each non-empty cell is predicted in a scoreboard, and
// every output word is compared field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module tb_tile_cell_to_sprite_descriptor_unit;
	import tcsd_pkg::*;

	localparam int     PIPE_DEPTH = 18;    // accept to out_valid
	localparam int     STALL_LIMIT = 5000; // cycles without any handshake
	localparam longint SRC_MAX = (longint'(1) << SRC_W) - 1;

	typedef struct {
		logic [SRC_W-1:0]  src_x;
		logic [SRC_W-1:0]  src_y;
		logic [DEST_W-1:0] dest_x;
		logic [DEST_W-1:0] dest_y;
		logic              mir_x;
		logic              mir_y;
		logic              rot;
	} sprite_desc_t;

	class sprite_scoreboard;
		sprite_desc_t pending_sprites[$];
		int errors;
		logic [TSIZE_W-1:0]       tile_w;
		logic [TSIZE_W-1:0]       tile_h;
		logic [GAP_W-1:0]         margin;
		logic [GAP_W-1:0]         spacing;
		logic [11:0]              atlas_cols;
		logic [COLS_W-1:0]        map_w;
		logic signed [OFF_W-1:0]  off_x;
		logic signed [OFF_W-1:0]  off_y;

		function new();
			errors = 0;
			tile_w = 16;
			tile_h = 16;
			margin = 0;
			spacing = 0;
			atlas_cols = 0;
			map_w = 64;
			off_x = 0;
			off_y = 0;
		endfunction

		function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
			case (idx)
				REG_TILE_WIDTH:    tile_w = data[TSIZE_W-1:0];
				REG_TILE_HEIGHT:   tile_h = data[TSIZE_W-1:0];
				REG_ATLAS_MARGIN:  margin = data[GAP_W-1:0];
				REG_ATLAS_SPACING: spacing = data[GAP_W-1:0];
				REG_ATLAS_COLUMNS: atlas_cols = data[11:0];
				REG_MAP_WIDTH:     map_w = data[COLS_W-1:0];
				REG_OFFSET_X:      off_x = data[OFF_W-1:0];
				REG_OFFSET_Y:      off_y = data[OFF_W-1:0];
				default: ;
			endcase
		endfunction

		// predict the descriptor of one accepted cell; empty cells give none
		function void note_cell(logic signed [IDX_W:0] tidx, logic [FLAG_W-1:0] flags,
				logic [COORD_W-1:0] col, logic [COORD_W-1:0] row);
			longint idx, cols, ax, ay, sx, sy, dx, dy, adj, tw, th, ox, oy;
			sprite_desc_t s;
			if (tidx[IDX_W])
				return;
			idx = tidx[IDX_W-1:0];
			cols = (atlas_cols != 0) ? longint'(atlas_cols) : longint'(map_w);
			if (cols == 0)
				cols = 1;
			ax = idx % cols;
			ay = idx / cols;
			tw = tile_w;
			th = tile_h;
			ox = off_x;
			oy = off_y;
			sx = longint'(margin) + ax * (tw + longint'(spacing));
			sy = longint'(margin) + ay * (th + longint'(spacing));
			adj = flags[FLAG_D] ? th - tw : 0;
			dx = ox + 2 * longint'(col) * tw + tw + adj;
			dy = oy + 2 * longint'(row) * th + th + adj;
			s.src_x = (sx > SRC_MAX) ? SRC_MAX[SRC_W-1:0] : sx[SRC_W-1:0];
			s.src_y = (sy > SRC_MAX) ? SRC_MAX[SRC_W-1:0] : sy[SRC_W-1:0];
			s.dest_x = dx[DEST_W-1:0];
			s.dest_y = dy[DEST_W-1:0];
			s.rot = flags[FLAG_D];
			s.mir_x = flags[FLAG_D] ? flags[FLAG_V] : flags[FLAG_H];
			s.mir_y = flags[FLAG_D] ? !flags[FLAG_H] : flags[FLAG_V];
			pending_sprites.push_back(s);
		endfunction

		function void check_field(string name, logic [DEST_W-1:0] want, logic [DEST_W-1:0] got);
			if (got !== want) begin
				$display("%0t: %s mismatch, expected %h got %h", $time, name, want, got);
				errors++;
			end
		endfunction

		function void check_sprite(sprite_desc_t got);
			sprite_desc_t want;
			if (pending_sprites.size() == 0) begin
				$display("%0t: output word with no prediction waiting", $time);
				errors++;
				return;
			end
			want = pending_sprites.pop_front();
			check_field("src_x", DEST_W'(want.src_x), DEST_W'(got.src_x));
			check_field("src_y", DEST_W'(want.src_y), DEST_W'(got.src_y));
			check_field("dest_x_half", want.dest_x, got.dest_x);
			check_field("dest_y_half", want.dest_y, got.dest_y);
			check_field("mirror_x", DEST_W'(want.mir_x), DEST_W'(got.mir_x));
			check_field("mirror_y", DEST_W'(want.mir_y), DEST_W'(got.mir_y));
			check_field("rotate_90", DEST_W'(want.rot), DEST_W'(got.rot));
		endfunction
	endclass

	logic                     clk = 1'b0;
	logic                     arst_n = 1'b0;
	logic                     cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0]     cfg_index = REG_TILE_WIDTH;
	logic [CFG_W-1:0]         cfg_data = '0;
	logic                     in_valid = 1'b0;
	logic                     in_ready;
	logic signed [IDX_W:0]    tile_index = '0;
	logic [FLAG_W-1:0]        flip_flags = '0;
	logic [COORD_W-1:0]       cell_col = '0;
	logic [COORD_W-1:0]       cell_row = '0;
	logic                     out_valid;
	logic                     out_ready = 1'b0;
	logic [SRC_W-1:0]         src_x;
	logic [SRC_W-1:0]         src_y;
	logic signed [DEST_W-1:0] dest_x_half;
	logic signed [DEST_W-1:0] dest_y_half;
	logic                     mirror_x;
	logic                     mirror_y;
	logic                     rotate_90;

	sprite_scoreboard sprites = new();
	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	int hold_left = 0;
	int quiet_cycles = 0;

	tile_cell_to_sprite_descriptor_unit dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.tile_index  (tile_index),
		.flip_flags  (flip_flags),
		.cell_col    (cell_col),
		.cell_row    (cell_row),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.src_x       (src_x),
		.src_y       (src_y),
		.dest_x_half (dest_x_half),
		.dest_y_half (dest_y_half),
		.mirror_x    (mirror_x),
		.mirror_y    (mirror_y),
		.rotate_90   (rotate_90)
	);

	always #2 clk = ~clk;

	// receiver: check accepted words, then pick next ready
	initial begin
		sprite_desc_t got;
		forever begin
			@(posedge clk);
			if (out_valid && out_ready) begin
				got.src_x = src_x;
				got.src_y = src_y;
				got.dest_x = dest_x_half;
				got.dest_y = dest_y_half;
				got.mir_x = mirror_x;
				got.mir_y = mirror_y;
				got.rot = rotate_90;
				sprites.check_sprite(got);
			end
			if (hold_left > 0) begin
				out_ready <= 1'b0;
				hold_left--;
			end else begin
				out_ready <= ($urandom_range(99) >= recv_stall_pct);
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("%0t: no handshake for %0d cycles", $time, STALL_LIMIT);
			$display("TB_ERROR");
			$finish;
		end
	end

	// offer one cell and hold it until accepted; called just after a rising edge
	task automatic drive_cell(logic signed [IDX_W:0] tidx, logic [FLAG_W-1:0] flags,
			logic [COORD_W-1:0] col, logic [COORD_W-1:0] row);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		tile_index <= tidx;
		flip_flags <= flags;
		cell_col <= col;
		cell_row <= row;
		do
			@(posedge clk);
		while (!in_ready);
		sprites.note_cell(tidx, flags, col, row);
	endtask

	function automatic logic [COORD_W-1:0] pick_coord();
		case ($urandom_range(9))
			0: return '0;
			1: return '1;
			default: return COORD_W'($urandom_range((1 << COORD_W) - 1));
		endcase
	endfunction

	// random cells; empty ones are extra and do not count toward n
	task automatic drive_random_cells(int n);
		int sent;
		int pick;
		logic signed [IDX_W:0] tidx;
		sent = 0;
		while (sent < n) begin
			pick = $urandom_range(99);
			if (pick < 10)
				tidx = {1'b1, IDX_W'($urandom)};
			else if (pick < 50)
				tidx = (IDX_W+1)'($urandom_range(1023));
			else
				tidx = (IDX_W+1)'($urandom_range((1 << IDX_W) - 1));
			drive_cell(tidx, FLAG_W'($urandom), pick_coord(), pick_coord());
			if (!tidx[IDX_W])
				sent++;
		end
	endtask

	// drop valid and wait for every predicted word; settle lets dropped cells drain
	task automatic wait_drained(bit settle);
		in_valid <= 1'b0;
		while (sprites.pending_sprites.size() != 0)
			@(posedge clk);
		if (settle)
			repeat (PIPE_DEPTH + 6) @(posedge clk);
	endtask

	task automatic write_settings(logic [TSIZE_W-1:0] tw, logic [TSIZE_W-1:0] th,
			logic [GAP_W-1:0] mg, logic [GAP_W-1:0] sp, logic [11:0] cols,
			logic [COLS_W-1:0] mw, logic [OFF_W-1:0] ox, logic [OFF_W-1:0] oy);
		logic [CFG_W-1:0] vals[8];
		logic [CFG_IDX_W-1:0] idx[8];
		vals = '{CFG_W'(tw), CFG_W'(th), CFG_W'(mg), CFG_W'(sp),
			CFG_W'(cols), CFG_W'(mw), CFG_W'(ox), CFG_W'(oy)};
		idx = '{REG_TILE_WIDTH, REG_TILE_HEIGHT, REG_ATLAS_MARGIN, REG_ATLAS_SPACING,
			REG_ATLAS_COLUMNS, REG_MAP_WIDTH, REG_OFFSET_X, REG_OFFSET_Y};
		for (int i = 0; i < 8; i++) begin
			cfg_we <= 1'b1;
			cfg_index <= idx[i];
			cfg_data <= vals[i];
			@(posedge clk);
			sprites.set_reg(idx[i], vals[i]);
		end
		cfg_we <= 1'b0;
	endtask

	task automatic write_random_settings();
		write_settings(TSIZE_W'($urandom_range(511)), TSIZE_W'($urandom_range(511)),
			GAP_W'($urandom), GAP_W'($urandom),
			($urandom_range(3) == 0) ? 12'd0 : 12'($urandom_range(4095)),
			COLS_W'($urandom_range(8191)), OFF_W'($urandom), OFF_W'($urandom));
	endtask

	task automatic set_idling(int send_pct, int recv_pct);
		send_idle_pct = send_pct;
		recv_stall_pct = recv_pct;
	endtask

	initial begin
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset defaults: field extremes, every flag combination, empty cells
		set_idling(0, 0);
		drive_cell(17'sd0, 3'b000, 12'd0, 12'd0);
		drive_cell(17'sd65535, 3'b111, 12'd4095, 12'd4095);
		drive_cell(-17'sd1, 3'b000, 12'd5, 12'd5);
		drive_cell(17'sh10000, 3'b111, 12'd4095, 12'd4095);
		drive_cell(17'sd63, 3'b001, 12'd1, 12'd2);
		drive_cell(17'sd64, 3'b010, 12'd3, 12'd4);
		drive_cell(17'sd65, 3'b011, 12'd4095, 12'd0);
		drive_cell(17'sd127, 3'b100, 12'd0, 12'd4095);
		drive_cell(17'sd128, 3'b101, 12'd17, 12'd33);
		drive_cell(17'sd4095, 3'b110, 12'd2048, 12'd2047);
		drive_cell(17'sd32768, 3'b111, 12'd1, 12'd1);
		drive_cell(17'sd21845, 3'b010, 12'hAAA, 12'h555);
		drive_cell(17'sd43690, 3'b101, 12'h555, 12'hAAA);
		wait_drained(1'b1);

		// widest sizes and gaps, zero column count, offsets at both limits
		write_settings(9'd511, 9'd511, 8'd255, 8'd255, 12'd0, 13'd0,
			22'h1FFFFF, 22'h200000);
		drive_cell(17'sd65535, 3'b000, 12'd4095, 12'd4095);
		drive_cell(17'sd65535, 3'b001, 12'd4095, 12'd4095);
		drive_cell(17'sd5475, 3'b100, 12'd0, 12'd0);
		drive_cell(17'sd5476, 3'b011, 12'd1, 12'd1);
		drive_random_cells(100);
		wait_drained(1'b1);

		// narrowest tiles, one column
		write_settings(9'd1, 9'd1, 8'd0, 8'd0, 12'd1, 13'd1, 22'd0, 22'd0);
		set_idling(60, 0);
		drive_random_cells(100);
		wait_drained(1'b1);

		// zero tile width, widest map and column count
		write_settings(9'd0, 9'd256, 8'd0, 8'd255, 12'd4095, 13'd8191,
			22'h200000, 22'h1FFFFF);
		set_idling(0, 60);
		drive_random_cells(100);
		wait_drained(1'b1);

		for (int p = 0; p < 3; p++) begin
			write_random_settings();
			case (p % 4)
				0: set_idling(23, 23);
				1: set_idling(0, 0);
				2: set_idling(60, 0);
				default: set_idling(0, 60);
			endcase
			drive_random_cells(100);
			wait_drained(1'b1);
		end

		// back-pressure: receiver holds off while the sender keeps offering
		write_random_settings();
		set_idling(0, 0);
		hold_left = 300;
		drive_random_cells(80);
		wait_drained(1'b0);
		set_idling(23, 23);
		drive_random_cells(40);

		wait_drained(1'b0);
		repeat (PIPE_DEPTH + 8) @(posedge clk);
		if (sprites.pending_sprites.size() != 0)
			$display("%0t: %0d predicted words never arrived", $time,
				sprites.pending_sprites.size());
		if (sprites.errors == 0 && sprites.pending_sprites.size() == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule

/* tile_cell_to_sprite_descriptor_unit.f */
hdl/tcsd_pkg.sv
hdl/tcsd_div_cell.sv
hdl/tcsd_finish.sv
hdl/tile_cell_to_sprite_descriptor_unit.sv
tb/tb_tile_cell_to_sprite_descriptor_unit.sv
